>>> sv/ppp_pkg.sv
// shared types, constants and helpers for the projectile pool
package ppp_pkg;

  localparam int SLOTS_DEFAULT = 16;
  localparam int REPORTS_MAX   = 16;

  localparam int POS_W     = 20;
  localparam int VEL_W     = 18;
  localparam int ANG_W     = 7;
  localparam int SPD_W     = 13;
  localparam int PIX_W     = 11;
  localparam int TRIG_W    = 15;
  localparam int FRAC_W    = 8;
  localparam int TRIG_FRAC = 14;
  localparam int GRAV_W    = 13;
  localparam int WIND_W    = 11;
  localparam int IDX_W     = 4;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [ANG_W-1:0] ANGLE_MAX = ANG_W'(90);

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_FIRE = 1'b1;

  localparam logic KIND_FIRE   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // sine of whole degrees, Q1.14
  localparam logic [TRIG_W-1:0] SINE_Q14 [91] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
  } slot_t;

  typedef struct packed {
    logic signed [GRAV_W-1:0] gravity;
    logic signed [WIND_W-1:0] wind;
    logic [PIX_W-1:0]         width;
    logic [PIX_W-1:0]         height;
  } cfg_t;

  typedef enum logic [1:0] {
    REG_GRAVITY = 2'd0,
    REG_WIND    = 2'd1,
    REG_WIDTH   = 2'd2,
    REG_HEIGHT  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRE_MUL,
    ST_FIRE_SCAN,
    ST_TICK
  } state_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
    if (v[POS_W] != v[POS_W-1]) begin
      return v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
    return v[POS_W-1:0];
  endfunction

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [VEL_W:0] v);
    if (v[VEL_W] != v[VEL_W-1]) begin
      return v[VEL_W] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
    end
    return v[VEL_W-1:0];
  endfunction

endpackage

>>> sv/projectile_pool_physics.sv
// projectile pool: slot memory, fire and tick sequencer, result registers
//
//  channel   handshake              fields
//  --------  ---------------------  ------------------------------------------------
//  command   start / busy           opcode launch_angle launch_speed launch_x launch_y
//  result    valid (one cycle)      reply_kind slot_index slot_alive pos_x pos_y last_item
//  config    psel penable pwrite    paddr pwdata prdata pready
//
// a command transfer happens when start is high and busy is low.
// fire: busy for a multiply, then a scan of one slot a cycle for a free one;
// its single reply shows up in the same cycle that busy drops.
// tick: one slot memory read-modify-write per cycle after the registered memory read;
// reports for slots 0..REPORTS-1 (max 16) follow one a cycle, registered with each write.
// rst clears alive, valid, state; sets config defaults; slot memory needs no clearing.
// results are strobed for one cycle with valid and cannot be held off.
module projectile_pool_physics #(
  parameter int SLOTS = ppp_pkg::SLOTS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              opcode,
  input  logic [ppp_pkg::ANG_W-1:0]         launch_angle,
  input  logic [ppp_pkg::SPD_W-1:0]         launch_speed,
  input  logic [ppp_pkg::PIX_W-1:0]         launch_x,
  input  logic [ppp_pkg::PIX_W-1:0]         launch_y,
  output logic                              valid,
  output logic                              reply_kind,
  output logic [ppp_pkg::IDX_W-1:0]         slot_index,
  output logic                              slot_alive,
  output logic signed [ppp_pkg::POS_W-1:0]  pos_x,
  output logic signed [ppp_pkg::POS_W-1:0]  pos_y,
  output logic                              last_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ppp_pkg::ADDR_W-1:0]        paddr,
  input  logic [ppp_pkg::DATA_W-1:0]        pwdata,
  output logic [ppp_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  import ppp_pkg::*;

  localparam int IDXW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int REPORTS = (SLOTS < REPORTS_MAX) ? SLOTS : REPORTS_MAX;
  localparam int PROD_W  = SPD_W + TRIG_W;
  localparam logic [IDXW-1:0]   LAST_IDX   = IDXW'(SLOTS - 1);
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (TRIG_FRAC - 1);

  cfg_t   cfg;
  state_t state, state_next;

  logic [SLOTS-1:0] alive, alive_next;
  logic [IDXW-1:0]  rd_idx;
  logic             rd_active;
  logic             proc_valid;
  logic [IDXW-1:0]  proc_idx;
  logic [IDXW-1:0]  scan_idx;

  logic [SPD_W-1:0]  speed_r;
  logic [PIX_W-1:0]  lx_r, ly_r;
  logic [TRIG_W-1:0] sin_q, cos_q;
  logic [PROD_W-1:0] prod_c, prod_s;
  logic [ANG_W-1:0]  ang_c;

  logic        ram_we;
  logic [IDXW-1:0] ram_waddr;
  slot_t       ram_wdata, ram_rdata;
  slot_t       step_nxt, fire_slot;
  logic        step_kill;
  logic        scan_free, proc_alive, accept;
  logic [PROD_W-1:0] rnd_c, rnd_s;
  logic signed [VEL_W-1:0] vel_c, vel_s;

  logic        valid_next, kind_next, slot_alive_next, last_next;
  logic [IDX_W-1:0] index_next;
  logic signed [POS_W-1:0] pos_x_next, pos_y_next;

  ppp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ppp_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  ppp_step u_step (
    .cur  (ram_rdata),
    .cfg  (cfg),
    .nxt  (step_nxt),
    .kill (step_kill)
  );

  assign busy       = (state != ST_IDLE);
  assign accept     = start & ~busy;
  assign scan_free  = ~alive[scan_idx];
  assign proc_alive = alive[proc_idx];
  assign ang_c      = (launch_angle > ANGLE_MAX) ? ANGLE_MAX : launch_angle;

  // launch velocity, rounded half up from Q.22 to Q10.8
  always_comb begin
    rnd_c = prod_c + ROUND_HALF;
    rnd_s = prod_s + ROUND_HALF;
    vel_c = VEL_W'(rnd_c[PROD_W-1:TRIG_FRAC]);
    vel_s = VEL_W'(rnd_s[PROD_W-1:TRIG_FRAC]);
    fire_slot.pos_x = {1'b0, lx_r, {FRAC_W{1'b0}}};
    fire_slot.pos_y = {1'b0, ly_r, {FRAC_W{1'b0}}};
    fire_slot.vel_x = vel_c;
    fire_slot.vel_y = VEL_W'(0) - vel_s;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (opcode == OP_FIRE) ? ST_FIRE_MUL : ST_TICK;
        end
      end
      ST_FIRE_MUL: state_next = ST_FIRE_SCAN;
      ST_FIRE_SCAN: begin
        if (scan_free || (scan_idx == LAST_IDX)) begin
          state_next = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (proc_valid && (proc_idx == LAST_IDX)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    alive_next      = alive;
    ram_we          = 1'b0;
    ram_waddr       = scan_idx;
    ram_wdata       = fire_slot;
    valid_next      = 1'b0;
    kind_next       = KIND_FIRE;
    index_next      = '0;
    slot_alive_next = 1'b0;
    pos_x_next      = '0;
    pos_y_next      = '0;
    last_next       = 1'b0;
    unique case (state)
      ST_FIRE_SCAN: begin
        if (scan_free) begin
          ram_we               = 1'b1;
          alive_next[scan_idx] = 1'b1;
          valid_next           = 1'b1;
          index_next           = IDX_W'(scan_idx);
          slot_alive_next      = 1'b1;
          pos_x_next           = fire_slot.pos_x;
          pos_y_next           = fire_slot.pos_y;
          last_next            = 1'b1;
        end else if (scan_idx == LAST_IDX) begin
          // pool full
          valid_next = 1'b1;
          last_next  = 1'b1;
        end
      end
      ST_TICK: begin
        if (proc_valid) begin
          if (proc_alive) begin
            ram_we               = 1'b1;
            ram_waddr            = proc_idx;
            ram_wdata            = step_nxt;
            alive_next[proc_idx] = ~step_kill;
          end
          if (int'(proc_idx) < REPORTS) begin
            valid_next      = 1'b1;
            kind_next       = KIND_REPORT;
            index_next      = IDX_W'(proc_idx);
            slot_alive_next = proc_alive & ~step_kill;
            if (proc_alive && !step_kill) begin
              pos_x_next = step_nxt.pos_x;
              pos_y_next = step_nxt.pos_y;
            end
            last_next = (int'(proc_idx) == REPORTS - 1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      alive      <= '0;
      valid      <= 1'b0;
      rd_active  <= 1'b0;
      rd_idx     <= '0;
      proc_valid <= 1'b0;
    end else begin
      state      <= state_next;
      alive      <= alive_next;
      valid      <= valid_next;
      proc_valid <= (state == ST_TICK) && rd_active;
      if (accept && (opcode == OP_TICK)) begin
        rd_active <= 1'b1;
        rd_idx    <= '0;
      end else if ((state == ST_TICK) && rd_active) begin
        if (rd_idx == LAST_IDX) begin
          rd_active <= 1'b0;
        end else begin
          rd_idx <= rd_idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    proc_idx <= rd_idx;
    if (accept) begin
      speed_r <= launch_speed;
      lx_r    <= launch_x;
      ly_r    <= launch_y;
      sin_q   <= SINE_Q14[ang_c];
      cos_q   <= SINE_Q14[ANGLE_MAX - ang_c];
    end
    if (state == ST_FIRE_MUL) begin
      prod_c   <= PROD_W'(speed_r) * PROD_W'(cos_q);
      prod_s   <= PROD_W'(speed_r) * PROD_W'(sin_q);
      scan_idx <= '0;
    end else if ((state == ST_FIRE_SCAN) && !scan_free && (scan_idx != LAST_IDX)) begin
      scan_idx <= scan_idx + 1'b1;
    end
    reply_kind <= kind_next;
    slot_index <= index_next;
    slot_alive <= slot_alive_next;
    pos_x      <= pos_x_next;
    pos_y      <= pos_y_next;
    last_item  <= last_next;
  end

endmodule

>>> sv/ppp_ram.sv
// generic single-write, single-read ram with registered read data
module ppp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/ppp_regs.sv
// apb configuration registers: gravity, wind and field limits
module ppp_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppp_pkg::ADDR_W-1:0]  paddr,
  input  logic [ppp_pkg::DATA_W-1:0]  pwdata,
  output logic [ppp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output ppp_pkg::cfg_t               cfg
);

  import ppp_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gravity <= GRAV_W'(51);
      cfg.wind    <= -WIND_W'(3);
      cfg.width   <= PIX_W'(640);
      cfg.height  <= PIX_W'(480);
    end else if (wr_en) begin
      unique case (idx)
        REG_GRAVITY: cfg.gravity <= pwdata[GRAV_W-1:0];
        REG_WIND:    cfg.wind    <= pwdata[WIND_W-1:0];
        REG_WIDTH:   cfg.width   <= pwdata[PIX_W-1:0];
        REG_HEIGHT:  cfg.height  <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GRAVITY: prdata = {{(DATA_W-GRAV_W){cfg.gravity[GRAV_W-1]}}, cfg.gravity};
      REG_WIND:    prdata = {{(DATA_W-WIND_W){cfg.wind[WIND_W-1]}}, cfg.wind};
      REG_WIDTH:   prdata = {{(DATA_W-PIX_W){1'b0}}, cfg.width};
      REG_HEIGHT:  prdata = {{(DATA_W-PIX_W){1'b0}}, cfg.height};
      default:     prdata = '0;
    endcase
  end

endmodule

>>> sv/ppp_step.sv
// one euler step of a slot with saturation and the out-of-field test
module ppp_step (
  input  ppp_pkg::slot_t cur,
  input  ppp_pkg::cfg_t  cfg,
  output ppp_pkg::slot_t nxt,
  output logic           kill
);

  import ppp_pkg::*;

  logic signed [POS_W:0] sum_x;
  logic signed [POS_W:0] sum_y;
  logic signed [VEL_W:0] sum_vx;
  logic signed [VEL_W:0] sum_vy;
  logic signed [POS_W:0] lim_x;
  logic signed [POS_W:0] lim_y;
  logic signed [POS_W:0] ext_x;
  logic signed [POS_W:0] ext_y;

  always_comb begin
    sum_x  = {cur.pos_x[POS_W-1], cur.pos_x}
           + {{(POS_W-VEL_W+1){cur.vel_x[VEL_W-1]}}, cur.vel_x};
    sum_y  = {cur.pos_y[POS_W-1], cur.pos_y}
           + {{(POS_W-VEL_W+1){cur.vel_y[VEL_W-1]}}, cur.vel_y};
    sum_vx = {cur.vel_x[VEL_W-1], cur.vel_x}
           + {{(VEL_W-WIND_W+1){cfg.wind[WIND_W-1]}}, cfg.wind};
    sum_vy = {cur.vel_y[VEL_W-1], cur.vel_y}
           + {{(VEL_W-GRAV_W+1){cfg.gravity[GRAV_W-1]}}, cfg.gravity};

    nxt.pos_x = sat_pos(sum_x);
    nxt.pos_y = sat_pos(sum_y);
    nxt.vel_x = sat_vel(sum_vx);
    nxt.vel_y = sat_vel(sum_vy);

    // limits in pixels moved up to the fixed-point grid
    lim_x = {{(POS_W+1-PIX_W-FRAC_W){1'b0}}, cfg.width, {FRAC_W{1'b0}}};
    lim_y = {{(POS_W+1-PIX_W-FRAC_W){1'b0}}, cfg.height, {FRAC_W{1'b0}}};
    ext_x = {nxt.pos_x[POS_W-1], nxt.pos_x};
    ext_y = {nxt.pos_y[POS_W-1], nxt.pos_y};

    kill = (ext_x >= lim_x) || (ext_y >= lim_y) || nxt.pos_y[POS_W-1];
  end

endmodule
